// File: rtl/orhb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orhb_pkg: shared types and codes of the ring history buffer
// Request and response beats, operation and result codes, queue sizing.
// ----------------------------------------------------------------------------
package orhb_pkg;

   // fixed field widths
   localparam int WORD_PORT_W = 32;
   localparam int COUNT_W     = 7;

   // operation codes of a request beat
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // result codes of a response beat
   localparam logic [1:0] KIND_PUSH_DONE  = 2'd0;
   localparam logic [1:0] KIND_ENTRY      = 2'd1;
   localparam logic [1:0] KIND_CLEAR_DONE = 2'd2;
   localparam logic [1:0] KIND_EMPTY      = 2'd3;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]             opcode;
      logic [WORD_PORT_W-1:0] entry_word;
      logic [COUNT_W-1:0]     max_entries;
   } req_type;

   typedef struct packed {
      logic [1:0]             result_kind;
      logic [WORD_PORT_W-1:0] entry_out;
      logic                   is_last;
      logic [COUNT_W-1:0]     stored_count;
   } rsp_type;

endpackage

// File: rtl/orhb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orhb_front: request intake and command queue
// Accepts request beats, drops undefined opcodes and queues the rest for
// the back end.
// ----------------------------------------------------------------------------
module orhb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  orhb_pkg::req_type req_item,
   output logic             cmd_valid,
   output orhb_pkg::req_type cmd_item,
   input  logic             cmd_pop
);
   import orhb_pkg::*;

   req_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   logic              push_q;
   logic              pop_q;

   // accept when there is room; opcode 3 is taken and dropped
   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign push_q    = accept && (req_item.opcode inside {OP_PUSH, OP_READ, OP_CLEAR});
   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = queue_ff[rd_ptr_ff];
   assign pop_q     = cmd_pop && cmd_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_q) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_q) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push_q, pop_q})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_q) begin
         queue_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// File: rtl/orhb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orhb_back: ring state, entry memory and response generation
// Executes queued commands one per cycle while no read is walking; a read
// walks the ring one entry per cycle through a registered memory read.
// ----------------------------------------------------------------------------
module orhb_back #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  orhb_pkg::req_type                 cmd_item,
   output logic                              cmd_pop,
   input  logic                              csr_write,
   input  logic [orhb_pkg::COUNT_W-1:0]      csr_data,
   output logic                              rsp_strobe,
   output orhb_pkg::rsp_type                 rsp_item
);
   import orhb_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [1:0] {
      ST_CMD  = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    cap_ff, cap_in;
   logic [IDX_W-1:0]      oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]      rd_left_ff, rd_left_in;

   logic                  meta_valid_ff, meta_valid_in;
   logic [1:0]            meta_kind_ff, meta_kind_in;
   logic                  meta_last_ff, meta_last_in;
   logic [CNT_W-1:0]      meta_count_ff, meta_count_in;

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  rd_en;

   logic [CNT_W-1:0]      cap_eff;
   logic [SUM_W-1:0]      push_sum;
   logic [SUM_W-1:0]      start_sum;
   logic [SUM_W-1:0]      next_idx;
   logic [SUM_W-1:0]      next_old;
   logic [CNT_W-1:0]      read_n;

   // effective capacity: zero acts as one, saturates at the depth
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if ({1'b0, cap_ff} > (COUNT_W + 1)'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   // ring index arithmetic, each index a single add and wrap; the read length is the smaller of request and count
   always_comb begin
      push_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff);
      if (push_sum >= SUM_W'(cap_eff)) begin
         push_sum = push_sum - SUM_W'(cap_eff);
      end
      next_old = SUM_W'(oldest_ff) + 1'b1;
      if (next_old >= SUM_W'(cap_eff)) begin
         next_old = '0;
      end
      if ({1'b0, cmd_item.max_entries} < (COUNT_W + 1)'(count_ff)) begin
         read_n = CNT_W'(cmd_item.max_entries);
      end else begin
         read_n = count_ff;
      end
      start_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff - read_n);
      if (start_sum >= SUM_W'(cap_eff)) begin
         start_sum = start_sum - SUM_W'(cap_eff);
      end
      next_idx = SUM_W'(rd_idx_ff) + 1'b1;
      if (next_idx >= SUM_W'(cap_eff)) begin
         next_idx = '0;
      end
   end

   // command execution and read walk
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_left_in    = rd_left_ff;
      meta_valid_in = 1'b0;
      meta_kind_in  = meta_kind_ff;
      meta_last_in  = 1'b1;
      meta_count_in = count_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = oldest_ff;
      rd_en         = 1'b0;
      case (state_ff)
         ST_CMD: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_item.opcode)
                  OP_PUSH: begin
                     wr_en         = 1'b1;
                     meta_valid_in = 1'b1;
                     meta_kind_in  = KIND_PUSH_DONE;
                     if (count_ff < cap_eff) begin
                        wr_addr  = IDX_W'(push_sum);
                        count_in = count_ff + 1'b1;
                     end else begin
                        oldest_in = IDX_W'(next_old);
                     end
                     meta_count_in = count_in;
                  end
                  OP_READ: begin
                     if (count_ff == '0 || cmd_item.max_entries == '0) begin
                        meta_valid_in = 1'b1;
                        meta_kind_in  = KIND_EMPTY;
                     end else begin
                        rd_idx_in  = IDX_W'(start_sum);
                        rd_left_in = read_n;
                        state_in   = ST_READ;
                     end
                  end
                  OP_CLEAR: begin
                     oldest_in     = '0;
                     count_in      = '0;
                     meta_valid_in = 1'b1;
                     meta_kind_in  = KIND_CLEAR_DONE;
                     meta_count_in = '0;
                  end
                  default: begin
                     meta_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en         = 1'b1;
            meta_valid_in = 1'b1;
            meta_kind_in  = KIND_ENTRY;
            meta_last_in  = (rd_left_ff == CNT_W'(1));
            rd_idx_in     = IDX_W'(next_idx);
            rd_left_in    = rd_left_ff - 1'b1;
            if (rd_left_ff == CNT_W'(1)) begin
               state_in = ST_CMD;
            end
         end
         default: begin
            state_in = ST_CMD;
         end
      endcase
      // capacity write empties the ring
      if (csr_write) begin
         cap_in    = csr_data;
         oldest_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CMD;
         cap_ff        <= COUNT_W'(64);
         oldest_ff     <= '0;
         count_ff      <= '0;
         rd_left_ff    <= '0;
         meta_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         rd_left_ff    <= rd_left_in;
         meta_valid_ff <= meta_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      meta_kind_ff  <= meta_kind_in;
      meta_last_ff  <= meta_last_in;
      meta_count_ff <= meta_count_in;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= WORD_WIDTH'(cmd_item.entry_word);
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // response beat
   assign rsp_strobe            = meta_valid_ff;
   assign rsp_item.result_kind  = meta_kind_ff;
   assign rsp_item.entry_out    = (meta_kind_ff == KIND_ENTRY) ?
                                  WORD_PORT_W'(rd_data_ff) : '0;
   assign rsp_item.is_last      = meta_last_ff;
   assign rsp_item.stored_count = COUNT_W'(meta_count_ff);

endmodule

// File: rtl/overwrite_ring_history_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_history_buffer_top: overwrite-oldest ring history buffer
// Keeps the newest words in a ring; push, read-newest and clear commands.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_item          beat taken when start && !busy
//  response  rsp_strobe, rsp_item           one-cycle strobe, no back-pressure
//  config    csr_valid, csr_ready, csr_data beat taken when valid && ready
//
// pushes and clears execute one per cycle while no read is walking; a read
// holds the back end for a setup step, then one memory read per entry.
// busy rises when the four-entry command queue is full; reset clears queue,
// ring pointers and count, not the memory.
// ----------------------------------------------------------------------------
module overwrite_ring_history_buffer_top #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  orhb_pkg::req_type            req_item,
   output logic                         rsp_strobe,
   output orhb_pkg::rsp_type            rsp_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [orhb_pkg::COUNT_W-1:0] csr_data
);
   import orhb_pkg::*;

   logic    cmd_valid;
   req_type cmd_item;
   logic    cmd_pop;

   // capacity register is always writable
   assign csr_ready = 1'b1;

   orhb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop)
   );

   orhb_back #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_item   (cmd_item),
      .cmd_pop    (cmd_pop),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
